// File: sv/mbt_pkg.sv
// Shared types, codes, arithmetic helpers and the sigmoid table for the MLP trainer.
package mbt_pkg;

    localparam int SIG_DEPTH = 1024;
    localparam int IDX_W     = $clog2(SIG_DEPTH);

    localparam logic [5:0] LAST_STEP = 6'd35;

    localparam logic [2:0] A_W    = 3'd0;
    localparam logic [2:0] A_ROM  = 3'd1;
    localparam logic [2:0] A_ACC  = 3'd2;
    localparam logic [2:0] A_DOUT = 3'd3;
    localparam logic [2:0] A_H0   = 3'd4;
    localparam logic [2:0] A_H1   = 3'd5;
    localparam logic [2:0] A_RATE = 3'd6;
    localparam logic [2:0] A_RD   = 3'd7;

    localparam logic [3:0] B_X0   = 4'd0;
    localparam logic [3:0] B_X1   = 4'd1;
    localparam logic [3:0] B_BIAS = 4'd2;
    localparam logic [3:0] B_H0   = 4'd3;
    localparam logic [3:0] B_H1   = 4'd4;
    localparam logic [3:0] B_ROMC = 4'd5;
    localparam logic [3:0] B_TY   = 4'd6;
    localparam logic [3:0] B_S    = 4'd7;
    localparam logic [3:0] B_DOUT = 4'd8;
    localparam logic [3:0] B_DH0  = 4'd9;
    localparam logic [3:0] B_DH1  = 4'd10;
    localparam logic [3:0] B_H0C  = 4'd11;
    localparam logic [3:0] B_H1C  = 4'd12;

    localparam logic [3:0] CAP_NONE = 4'd0;
    localparam logic [3:0] CAP_ADDR = 4'd1;
    localparam logic [3:0] CAP_H0   = 4'd2;
    localparam logic [3:0] CAP_H1   = 4'd3;
    localparam logic [3:0] CAP_Y    = 4'd4;
    localparam logic [3:0] CAP_DOUT = 4'd5;
    localparam logic [3:0] CAP_S    = 4'd6;
    localparam logic [3:0] CAP_DH0  = 4'd7;
    localparam logic [3:0] CAP_DH1  = 4'd8;
    localparam logic [3:0] CAP_RD   = 4'd9;
    localparam logic [3:0] CAP_WB   = 4'd10;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRAIN = 1'b1;

    localparam logic [1:0] ADDR_RATE = 2'd0;

    typedef struct packed {
        logic       mac_en;
        logic       keep;
        logic [2:0] a_sel;
        logic [3:0] b_sel;
        logic [3:0] widx;
        logic [3:0] cap;
        logic       last;
    } ctrl_t;

    typedef logic [12:0] sig_tab_t [SIG_DEPTH];

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
            r = 16'sh7fff;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_pos(input logic [63:0] f);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 25; k++)
        begin
            term = udiv((term * f) >> 30, 64'(k));
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic sig_tab_t build_sig();
        sig_tab_t           tab;
        logic [63:0]        em1;
        logic [63:0]        num;
        logic signed [63:0] z;
        logic [63:0]        a;
        logic [63:0]        n;
        logic [63:0]        f;
        logic [63:0]        e;
        logic [63:0]        d;
        logic [63:0]        val;
        em1 = udiv(64'd1 << 60, exp_pos(64'd1 << 30));
        for (int i = 0; i < SIG_DEPTH; i++)
        begin
            num = (64'(2 * i + 1) << 33) / SIG_DEPTH;
            z   = $signed(num) - (64'sd1 <<< 33);
            a   = (z < 0) ? 64'(-z) : 64'(z);
            n   = a >> 30;
            f   = a & ((64'd1 << 30) - 64'd1);
            e   = udiv(64'd1 << 60, exp_pos(f));
            for (int k = 0; k < 16; k++)
            begin
                if (64'(k) < n)
                    e = (e * em1) >> 30;
            end
            d = (64'd1 << 30) + e;
            if (z >= 0)
                val = udiv((64'd4096 << 30) + (d >> 1), d);
            else
                val = udiv(64'd4096 * e + (d >> 1), d);
            tab[i] = val[12:0];
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig();

endpackage

// File: sv/mlp_backprop_trainer_core.sv
// Top level of the 2-2-1 sigmoid MLP online backpropagation trainer.
// A load beat (tuser 0) writes one weight if its index is below 9 and returns an
// all-zero result beat in the next cycle. A train beat (tuser 1) runs through one
// shared 32x32 multiply-accumulate unit and a registered sigmoid table: three forward
// passes, the output and hidden deltas, then nine weight updates; its result beat
// carries the output and hidden activations computed before the update. The next
// input beat is taken once the sequence ends and the result register is free.
module mlp_backprop_trainer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // weight_index[3:0], weight_value[19:4], x_first[35:20],
                                  // x_second[51:36], target[52]
    input  logic        s_tuser,  // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // prediction[12:0], hidden_first[25:13], hidden_second[38:26]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mbt_pkg::ctrl_t ctrl;
    logic           busy;
    logic           in_acc;
    logic           start;
    logic           cfg_wr;

    logic [12:0]        rate_reg;
    logic signed [15:0] w_reg [9];
    logic signed [15:0] x0_reg;
    logic signed [15:0] x1_reg;
    logic               t_reg;
    logic [12:0]        h0_reg;
    logic [12:0]        h1_reg;
    logic [12:0]        y_reg;
    logic signed [31:0] dout_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] dh0_reg;
    logic signed [31:0] dh1_reg;
    logic signed [31:0] rd_reg;

    logic               out_valid_reg;
    logic [12:0]        pred_reg;
    logic [12:0]        oh0_reg;
    logic [12:0]        oh1_reg;

    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] acc;
    logic signed [63:0] r12;
    logic signed [63:0] r24;
    logic signed [15:0] zq;
    logic [15:0]        uz;
    logic [12:0]        rom_data;
    logic signed [15:0] w_sel;
    logic signed [15:0] wb_val;
    logic [3:0]         ld_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2:1] == mbt_pkg::ADDR_RATE) ? {19'd0, rate_reg} : 32'd0;

    assign s_tready = !busy && (!out_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign start    = in_acc && (s_tuser == mbt_pkg::OP_TRAIN);
    assign ld_idx   = s_tdata[3:0];

    mbt_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    assign w_sel = (ctrl.widx < 4'd9) ? w_reg[ctrl.widx] : 16'sd0;

    always_comb
    begin
        case (ctrl.a_sel)
            mbt_pkg::A_W:    op_a = 32'(w_sel);
            mbt_pkg::A_ROM:  op_a = $signed({19'd0, rom_data});
            mbt_pkg::A_ACC:  op_a = acc[31:0];
            mbt_pkg::A_DOUT: op_a = dout_reg;
            mbt_pkg::A_H0:   op_a = $signed({19'd0, h0_reg});
            mbt_pkg::A_H1:   op_a = $signed({19'd0, h1_reg});
            mbt_pkg::A_RATE: op_a = $signed({19'd0, rate_reg});
            mbt_pkg::A_RD:   op_a = rd_reg;
            default:         op_a = 32'sd0;
        endcase
    end

    always_comb
    begin
        case (ctrl.b_sel)
            mbt_pkg::B_X0:   op_b = 32'(x0_reg);
            mbt_pkg::B_X1:   op_b = 32'(x1_reg);
            mbt_pkg::B_BIAS: op_b = -32'sd4096;
            mbt_pkg::B_H0:   op_b = $signed({19'd0, h0_reg});
            mbt_pkg::B_H1:   op_b = $signed({19'd0, h1_reg});
            mbt_pkg::B_ROMC: op_b = 32'sd4096 - $signed({19'd0, rom_data});
            mbt_pkg::B_TY:   op_b = (t_reg ? 32'sd4096 : 32'sd0) - $signed({19'd0, y_reg});
            mbt_pkg::B_S:    op_b = s_reg;
            mbt_pkg::B_DOUT: op_b = dout_reg;
            mbt_pkg::B_DH0:  op_b = dh0_reg;
            mbt_pkg::B_DH1:  op_b = dh1_reg;
            mbt_pkg::B_H0C:  op_b = 32'sd4096 - $signed({19'd0, h0_reg});
            mbt_pkg::B_H1C:  op_b = 32'sd4096 - $signed({19'd0, h1_reg});
            default:         op_b = 32'sd0;
        endcase
    end

    mbt_mac u_mac
    (
        .clk  (clk),
        .en   (ctrl.mac_en),
        .keep (ctrl.keep),
        .a    (op_a),
        .b    (op_b),
        .acc  (acc)
    );

    assign r12    = (acc + 64'sd2048) >>> 12;
    assign r24    = (acc + 64'sd8388608) >>> 24;
    assign zq     = mbt_pkg::sat16(r12);
    assign uz     = {~zq[15], zq[14:0]};
    assign wb_val = mbt_pkg::sat16(64'(w_sel) + r24);

    mbt_sig_rom u_rom
    (
        .clk  (clk),
        .en   (ctrl.cap == mbt_pkg::CAP_ADDR),
        .addr (uz[15 -: mbt_pkg::IDX_W]),
        .data (rom_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 13'd1229;
        end
        else if (cfg_wr && paddr[2:1] == mbt_pkg::ADDR_RATE && !paddr[0])
        begin
            rate_reg <= pwdata[12:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                w_reg[i] <= '0;
        end
        else if (in_acc && s_tuser == mbt_pkg::OP_LOAD)
        begin
            if (ld_idx < 4'd9)
                w_reg[ld_idx] <= $signed(s_tdata[19:4]);
        end
        else if (ctrl.cap == mbt_pkg::CAP_WB && ctrl.widx < 4'd9)
        begin
            w_reg[ctrl.widx] <= wb_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x0_reg <= $signed(s_tdata[35:20]);
            x1_reg <= $signed(s_tdata[51:36]);
            t_reg  <= s_tdata[52];
        end
        case (ctrl.cap)
            mbt_pkg::CAP_H0:   h0_reg   <= rom_data;
            mbt_pkg::CAP_H1:   h1_reg   <= rom_data;
            mbt_pkg::CAP_Y:    y_reg    <= rom_data;
            mbt_pkg::CAP_DOUT: dout_reg <= r12[31:0];
            mbt_pkg::CAP_S:    s_reg    <= r12[31:0];
            mbt_pkg::CAP_DH0:  dh0_reg  <= r24[31:0];
            mbt_pkg::CAP_DH1:  dh1_reg  <= r24[31:0];
            mbt_pkg::CAP_RD:   rd_reg   <= r12[31:0];
            default:           ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((in_acc && s_tuser == mbt_pkg::OP_LOAD) || ctrl.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && s_tuser == mbt_pkg::OP_LOAD)
        begin
            pred_reg <= '0;
            oh0_reg  <= '0;
            oh1_reg  <= '0;
        end
        else if (ctrl.last)
        begin
            pred_reg <= y_reg;
            oh0_reg  <= h0_reg;
            oh1_reg  <= h1_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, oh1_reg, oh0_reg, pred_reg};

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_tready)
        else $error("input taken during a training sequence");

    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.last |=> (m_tvalid && !busy))
        else $error("training sequence ended without a result beat");

    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser == mbt_pkg::OP_LOAD) |=> (m_tvalid && m_tdata == 40'd0))
        else $error("load beat did not return a zero result");

endmodule

// File: sv/mbt_sig_rom.sv
// Sigmoid lookup table with registered read.
module mbt_sig_rom
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [mbt_pkg::IDX_W-1:0] addr,
    output logic [12:0]             data
);

    logic [12:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= mbt_pkg::SIG_TAB[addr];
    end

    assign data = data_reg;

endmodule

// File: sv/mbt_mac.sv
// Shared signed 32x32 multiply-accumulate unit.
module mbt_mac
(
    input  logic               clk,
    input  logic               en,
    input  logic               keep,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] acc
);

    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;

    always_comb
    begin
        acc_next = (keep ? acc_reg : 64'sd0) + a * b;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: sv/mbt_seq.sv
// Step sequencer for one training sample.
module mbt_seq
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output mbt_pkg::ctrl_t ctrl
);

    logic       busy_reg;
    logic       busy_next;
    logic [5:0] step_reg;
    logic [5:0] step_next;

    function automatic mbt_pkg::ctrl_t mk(input logic mac, input logic keep,
                                          input logic [2:0] a, input logic [3:0] b,
                                          input logic [3:0] w, input logic [3:0] cap);
        mbt_pkg::ctrl_t c;
        c.mac_en = mac;
        c.keep   = keep;
        c.a_sel  = a;
        c.b_sel  = b;
        c.widx   = w;
        c.cap    = cap;
        c.last   = 1'b0;
        return c;
    endfunction

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 6'd1;
            if (step_reg == mbt_pkg::LAST_STEP)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        ctrl = mk(1'b0, 1'b0, mbt_pkg::A_W, mbt_pkg::B_X0, 4'd0, mbt_pkg::CAP_NONE);
        case (step_reg)
            6'd0:  ctrl = mk(1'b1, 1'b0, mbt_pkg::A_W, mbt_pkg::B_X0, 4'd0, mbt_pkg::CAP_NONE);
            6'd1:  ctrl = mk(1'b1, 1'b1, mbt_pkg::A_W, mbt_pkg::B_X1, 4'd1, mbt_pkg::CAP_NONE);
            6'd2:  ctrl = mk(1'b1, 1'b1, mbt_pkg::A_W, mbt_pkg::B_BIAS, 4'd2, mbt_pkg::CAP_NONE);
            6'd3:  ctrl = mk(1'b1, 1'b0, mbt_pkg::A_W, mbt_pkg::B_X0, 4'd3, mbt_pkg::CAP_ADDR);
            6'd4:  ctrl = mk(1'b1, 1'b1, mbt_pkg::A_W, mbt_pkg::B_X1, 4'd4, mbt_pkg::CAP_H0);
            6'd5:  ctrl = mk(1'b1, 1'b1, mbt_pkg::A_W, mbt_pkg::B_BIAS, 4'd5, mbt_pkg::CAP_NONE);
            6'd6:  ctrl = mk(1'b0, 1'b0, mbt_pkg::A_W, mbt_pkg::B_X0, 4'd0, mbt_pkg::CAP_ADDR);
            6'd7:  ctrl = mk(1'b1, 1'b0, mbt_pkg::A_W, mbt_pkg::B_H0, 4'd6, mbt_pkg::CAP_H1);
            6'd8:  ctrl = mk(1'b1, 1'b1, mbt_pkg::A_W, mbt_pkg::B_H1, 4'd7, mbt_pkg::CAP_NONE);
            6'd9:  ctrl = mk(1'b1, 1'b1, mbt_pkg::A_W, mbt_pkg::B_BIAS, 4'd8, mbt_pkg::CAP_NONE);
            6'd10: ctrl = mk(1'b0, 1'b0, mbt_pkg::A_W, mbt_pkg::B_X0, 4'd0, mbt_pkg::CAP_ADDR);
            6'd11: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_ROM, mbt_pkg::B_ROMC, 4'd0, mbt_pkg::CAP_Y);
            6'd12: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_ACC, mbt_pkg::B_TY, 4'd0, mbt_pkg::CAP_NONE);
            6'd13: ctrl = mk(1'b0, 1'b0, mbt_pkg::A_W, mbt_pkg::B_X0, 4'd0, mbt_pkg::CAP_DOUT);
            6'd14: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_W, mbt_pkg::B_DOUT, 4'd6, mbt_pkg::CAP_NONE);
            6'd15: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_H0, mbt_pkg::B_H0C, 4'd0, mbt_pkg::CAP_S);
            6'd16: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_ACC, mbt_pkg::B_S, 4'd0, mbt_pkg::CAP_NONE);
            6'd17: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_W, mbt_pkg::B_DOUT, 4'd7, mbt_pkg::CAP_DH0);
            6'd18: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_H1, mbt_pkg::B_H1C, 4'd0, mbt_pkg::CAP_S);
            6'd19: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_ACC, mbt_pkg::B_S, 4'd0, mbt_pkg::CAP_NONE);
            6'd20: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RATE, mbt_pkg::B_DOUT, 4'd0, mbt_pkg::CAP_DH1);
            6'd21: ctrl = mk(1'b0, 1'b0, mbt_pkg::A_W, mbt_pkg::B_X0, 4'd0, mbt_pkg::CAP_RD);
            6'd22: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RD, mbt_pkg::B_H0, 4'd0, mbt_pkg::CAP_NONE);
            6'd23: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RD, mbt_pkg::B_H1, 4'd6, mbt_pkg::CAP_WB);
            6'd24: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RD, mbt_pkg::B_BIAS, 4'd7, mbt_pkg::CAP_WB);
            6'd25: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RATE, mbt_pkg::B_DH0, 4'd8, mbt_pkg::CAP_WB);
            6'd26: ctrl = mk(1'b0, 1'b0, mbt_pkg::A_W, mbt_pkg::B_X0, 4'd0, mbt_pkg::CAP_RD);
            6'd27: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RD, mbt_pkg::B_X0, 4'd0, mbt_pkg::CAP_NONE);
            6'd28: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RD, mbt_pkg::B_X1, 4'd0, mbt_pkg::CAP_WB);
            6'd29: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RD, mbt_pkg::B_BIAS, 4'd1, mbt_pkg::CAP_WB);
            6'd30: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RATE, mbt_pkg::B_DH1, 4'd2, mbt_pkg::CAP_WB);
            6'd31: ctrl = mk(1'b0, 1'b0, mbt_pkg::A_W, mbt_pkg::B_X0, 4'd0, mbt_pkg::CAP_RD);
            6'd32: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RD, mbt_pkg::B_X0, 4'd0, mbt_pkg::CAP_NONE);
            6'd33: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RD, mbt_pkg::B_X1, 4'd3, mbt_pkg::CAP_WB);
            6'd34: ctrl = mk(1'b1, 1'b0, mbt_pkg::A_RD, mbt_pkg::B_BIAS, 4'd4, mbt_pkg::CAP_WB);
            6'd35: ctrl = mk(1'b0, 1'b0, mbt_pkg::A_W, mbt_pkg::B_X0, 4'd5, mbt_pkg::CAP_WB);
            default: ctrl = mk(1'b0, 1'b0, mbt_pkg::A_W, mbt_pkg::B_X0, 4'd0, mbt_pkg::CAP_NONE);
        endcase
        ctrl.last = (step_reg == mbt_pkg::LAST_STEP);
        if (!busy_reg)
        begin
            ctrl.mac_en = 1'b0;
            ctrl.cap    = mbt_pkg::CAP_NONE;
            ctrl.last   = 1'b0;
        end
    end

    assign busy = busy_reg;

endmodule

// File: bench/mlp_backprop_trainer_core_test.sv
// Self-checking testbench for the 2-2-1 sigmoid MLP backpropagation trainer core.
module mlp_backprop_trainer_core_test;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 60;
    localparam int LUT_DEPTH  = mbt_pkg::SIG_DEPTH;
    localparam int BIAS_IN    = -4096;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    class trainer_scoreboard;
        typedef struct {
            logic [12:0] y;
            logic [12:0] h0;
            logic [12:0] h1;
        } act_t;

        act_t               activations_q[$];
        logic [12:0]        sig_lut[LUT_DEPTH];
        logic signed [15:0] w[9];
        logic [12:0]        rate;
        int                 mismatches;
        int                 matched;
        int                 loads;
        int                 trains;

        function new();
            build_lut();
            foreach (w[i])
                w[i] = '0;
            rate = 13'd1229;
        endfunction

        function longint unsigned exp_q30(longint unsigned f);
            longint unsigned sum;
            longint unsigned term;
            sum  = 64'd1 << 30;
            term = 64'd1 << 30;
            for (int k = 1; k <= 25; k++)
            begin
                term = ((term * f) >> 30) / longint'(k);
                sum  = sum + term;
            end
            return sum;
        endfunction

        function void build_lut();
            longint unsigned em1;
            longint unsigned num;
            longint unsigned a;
            longint unsigned n;
            longint unsigned f;
            longint unsigned e;
            longint unsigned d;
            longint unsigned val;
            longint          z;
            em1 = (64'd1 << 60) / exp_q30(64'd1 << 30);
            for (int i = 0; i < LUT_DEPTH; i++)
            begin
                num = (longint'(2 * i + 1) << 33) / LUT_DEPTH;
                z   = longint'(num) - (64'sd1 <<< 33);
                a   = (z < 0) ? -z : z;
                n   = a >> 30;
                f   = a & ((64'd1 << 30) - 1);
                e   = (64'd1 << 60) / exp_q30(f);
                for (longint unsigned k = 0; k < n; k++)
                    e = (e * em1) >> 30;
                d = (64'd1 << 30) + e;
                if (z >= 0)
                    val = ((64'd4096 << 30) + d / 2) / d;
                else
                    val = (64'd4096 * e + d / 2) / d;
                sig_lut[i] = val[12:0];
            end
        endfunction

        function longint rnd(longint v, int k);
            return (v + (64'sd1 <<< (k - 1))) >>> k;
        endfunction

        function longint sat(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        function longint fire(longint wa, longint wb, longint wc, longint va, longint vb);
            longint s;
            longint zq;
            longint idx;
            s   = wa * va + wb * vb + wc * BIAS_IN;
            zq  = sat(rnd(s, 12));
            idx = ((zq + 32768) * LUT_DEPTH) >>> 16;
            return longint'(sig_lut[idx]);
        endfunction

        function void nudge(int base, longint delta, longint va, longint vb);
            longint rd;
            longint v[3];
            rd   = rnd(longint'(rate) * delta, 12);
            v[0] = va;
            v[1] = vb;
            v[2] = BIAS_IN;
            for (int i = 0; i < 3; i++)
                w[base + i] = 16'(sat(longint'(w[base + i]) + rnd(rd * v[i], 24)));
        endfunction

        function void note_beat(logic op, logic [3:0] idx, logic signed [15:0] val,
                                logic signed [15:0] x0, logic signed [15:0] x1, logic t);
            act_t   r;
            longint h0;
            longint h1;
            longint y;
            longint dout;
            longint dh0;
            longint dh1;
            r = '{13'd0, 13'd0, 13'd0};
            if (op == mbt_pkg::OP_LOAD)
            begin
                loads++;
                if (idx < 9)
                    w[idx] = val;
            end
            else
            begin
                trains++;
                h0   = fire(w[0], w[1], w[2], x0, x1);
                h1   = fire(w[3], w[4], w[5], x0, x1);
                y    = fire(w[6], w[7], w[8], h0, h1);
                r    = '{13'(y), 13'(h0), 13'(h1)};
                dout = rnd(y * (4096 - y) * (longint'(t) * 4096 - y), 12);
                dh0  = rnd(h0 * (4096 - h0) * rnd(dout * longint'(w[6]), 12), 24);
                dh1  = rnd(h1 * (4096 - h1) * rnd(dout * longint'(w[7]), 12), 24);
                nudge(6, dout, h0, h1);
                nudge(0, dh0, x0, x1);
                nudge(3, dh1, x0, x1);
            end
            activations_q = {activations_q, r};
        endfunction

        function void check_beat(logic [39:0] d);
            act_t r;
            if (activations_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", d);
                return;
            end
            r = activations_q.pop_front();
            if (d[12:0] !== r.y || d[25:13] !== r.h0 || d[38:26] !== r.h1)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp y=%0d h0=%0d h1=%0d, got y=%0d h0=%0d h1=%0d",
                             r.y, r.h0, r.h1, d[12:0], d[25:13], d[38:26]);
            end
            else
                matched++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;  // weight_index, weight_value, x_first, x_second, target
    logic        s_tuser = 1'b0; // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // prediction, hidden_first, hidden_second
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    trainer_scoreboard sb = new();
    int burst_left = 0;
    int hold_req = 0;
    int idle_cycles = 0;

    mlp_backprop_trainer_core uut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        int phase;
        int hold_left;
        phase = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready && rst_n)
                sb.check_beat(m_tdata);
            phase++;
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if ((phase / 250) % 3 == 0)
                m_tready <= 1'b1;
            else if ((phase / 250) % 3 == 1)
                m_tready <= ($urandom_range(0, 1) == 1);
            else
                m_tready <= ($urandom_range(0, 9) != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[mlp_backprop_trainer_core] ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == {mbt_pkg::ADDR_RATE, 1'b0} << 1)
            sb.rate = value[12:0];
    endtask

    task automatic send(logic op, logic [3:0] idx, logic signed [15:0] val,
                        logic signed [15:0] x0, logic signed [15:0] x1, logic t);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, t, x1, x0, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_beat(op, idx, val, x0, x1, t);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.activations_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'sh7fff;
            2: return 16'sh8000;
            default: return 16'($signed($urandom_range(0, 16383)) - 8192);
        endcase
    endfunction

    task automatic random_items(int count);
        logic [3:0] idx;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
                send(mbt_pkg::OP_LOAD, idx, pick_value(), 16'($urandom), 16'($urandom),
                     1'($urandom));
            end
            else
                send(mbt_pkg::OP_TRAIN, 4'($urandom), 16'($urandom), pick_value(),
                     pick_value(), 1'($urandom));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg({mbt_pkg::ADDR_RATE, 1'b0} << 1, 32'd1229);

        send(mbt_pkg::OP_TRAIN, 4'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        send(mbt_pkg::OP_TRAIN, 4'd0, 16'sd0, 16'sh7fff, 16'sh8000, 1'b0);
        for (int i = 0; i < 9; i++)
            send(mbt_pkg::OP_LOAD, 4'(i), (i % 2) ? 16'sh7fff : 16'sh8000, 16'sd0, 16'sd0,
                 1'b0);
        send(mbt_pkg::OP_LOAD, 4'd15, 16'sh1234, 16'sh7fff, 16'sh7fff, 1'b1);
        send(mbt_pkg::OP_LOAD, 4'd9, 16'shffff, 16'sd0, 16'sd0, 1'b0);
        send(mbt_pkg::OP_TRAIN, 4'd0, 16'sd0, 16'sh7fff, 16'sh7fff, 1'b1);
        send(mbt_pkg::OP_TRAIN, 4'd0, 16'sd0, 16'sh8000, 16'sh8000, 1'b0);
        for (int i = 0; i < 9; i++)
            send(mbt_pkg::OP_LOAD, 4'(i), 16'(($signed(i) - 4) * 900), 16'sd0, 16'sd0, 1'b0);
        send(mbt_pkg::OP_TRAIN, 4'd0, 16'sd0, 16'sd4096, 16'sh8000 + 16'sd4096, 1'b1);
        send(mbt_pkg::OP_TRAIN, 4'd0, 16'sd0, -16'sd4096, 16'sd2048, 1'b0);
        drain();

        write_reg({mbt_pkg::ADDR_RATE, 1'b0} << 1, 32'd4096);
        random_items(300);
        drain();
        write_reg({mbt_pkg::ADDR_RATE, 1'b0} << 1, 32'd0);
        random_items(150);
        drain();
        write_reg(ADDR_UNUSED, 32'd77);
        write_reg({mbt_pkg::ADDR_RATE, 1'b0} << 1, 32'hffff_ffff);
        random_items(200);
        drain();
        hold_req = 1;
        random_items(100);
        drain();
        write_reg({mbt_pkg::ADDR_RATE, 1'b0} << 1, $urandom_range(1, 4096));
        random_items(500);
        drain();

        $display("covered %0d loads and %0d training samples, %0d results matched",
                 sb.loads, sb.trains, sb.matched);
        $display("rates 0, 1229, 4096, 8191 and random; long output stall and drains");
        if (sb.mismatches == 0 && sb.activations_q.size() == 0)
            $display("[mlp_backprop_trainer_core] OK");
        else
            $display("[mlp_backprop_trainer_core] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
sv/mbt_pkg.sv
sv/mbt_sig_rom.sv
sv/mbt_mac.sv
sv/mbt_seq.sv
sv/mlp_backprop_trainer_core.sv
bench/mlp_backprop_trainer_core_test.sv
